FILE: rtl/imu_fsc_pkg.sv
// ----------------------------------------------------------------------------
// IMU frame parser package
// Shared constants, types and the field-to-word map of the frame parser.
// ----------------------------------------------------------------------------
package imu_fsc_pkg;

  localparam int unsigned FRAME_BYTES = 68;
  localparam int unsigned WORD_COUNT  = 33;
  localparam int unsigned MEM_WORDS   = (FRAME_BYTES + 3) / 4;
  localparam int unsigned MEM_AW      = $clog2(MEM_WORDS);
  localparam int unsigned POS_W       = 7;

  localparam logic [POS_W-1:0] POS_HUNT      = 7'd0;
  localparam logic [POS_W-1:0] POS_SYNC      = 7'd1;
  localparam logic [POS_W-1:0] POS_SUM_END   = 7'(2 * WORD_COUNT);
  localparam logic [POS_W-1:0] POS_CHECK_HI  = 7'd66;
  localparam logic [POS_W-1:0] POS_CHECK_LO  = 7'd67;
  localparam logic [POS_W-1:0] POS_FRAME_END = 7'(FRAME_BYTES);

  localparam logic [7:0] SYNC_FIRST_RST  = 8'h55;
  localparam logic [7:0] SYNC_SECOND_RST = 8'hAA;

  localparam logic CFG_SYNC_FIRST  = 1'b0;
  localparam logic CFG_SYNC_SECOND = 1'b1;

  localparam logic [3:0] FIELD_MSG_COUNT   = 4'd0;
  localparam logic [3:0] FIELD_LAST_RATE   = 4'd6;
  localparam logic [3:0] FIELD_LAST_DELTA  = 4'd13;
  localparam logic [3:0] FIELD_START_FLAGS = 4'd14;
  localparam logic [3:0] FIELD_OP_FLAGS    = 4'd15;

  typedef struct packed {
    logic              en;
    logic [MEM_AW-1:0] addr;
    logic [1:0]        lane;
    logic [7:0]        data;
  } wr_t;

  typedef struct packed {
    logic              en;
    logic [MEM_AW-1:0] addr;
  } rd_t;

  // Word of the frame store that holds a given output field.
  function automatic logic [MEM_AW-1:0] field_word(input logic [3:0] idx);
    logic [MEM_AW-1:0] w;
    if (idx == FIELD_MSG_COUNT) begin
      w = '0;
    end else if (idx <= FIELD_LAST_RATE) begin
      w = MEM_AW'(idx);
    end else if (idx <= FIELD_LAST_DELTA) begin
      w = MEM_AW'(idx) + MEM_AW'(1);
    end else begin
      w = MEM_AW'(4'd15);
    end
    return w;
  endfunction

endpackage

FILE: rtl/imu_frame_sync_checksum_parser_core.sv
// ----------------------------------------------------------------------------
// IMU frame sync and checksum parser
// Hunts for a two-byte sync pair, collects a 68-byte frame and emits its
// sixteen fields when the checksum matches.
// ----------------------------------------------------------------------------
// The parser takes one received byte per cycle while it hunts or collects a
// frame; each frame byte is written into a 17-word frame memory in the same
// cycle. When the last byte of a frame with a good checksum arrives, the
// single read port of that memory fetches one field per cycle, so the sixteen
// results leave at one per cycle under no back-pressure, and input stays
// stalled while the read port is busy. A bad frame does not stall the input.
module imu_frame_sync_checksum_parser_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  field_index_o,
  output logic [31:0] field_value_o,
  output logic        last_field_o
);
  import imu_fsc_pkg::*;

  wr_t         wr;
  rd_t         rd;
  logic [31:0] rd_data;
  logic        frame_ok;
  logic        busy;
  logic        accept;

  assign in_ready_o = !busy;
  assign accept     = in_valid_i && in_ready_o;

  imu_fsc_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .rx_byte_i   (rx_byte_i),
    .wr_o        (wr),
    .frame_ok_o  (frame_ok)
  );

  imu_fsc_store u_store (
    .clk_i     (clk_i),
    .wr_i      (wr),
    .rd_i      (rd),
    .rd_data_o (rd_data)
  );

  imu_fsc_emit u_emit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (frame_ok),
    .rd_data_i     (rd_data),
    .rd_o          (rd),
    .busy_o        (busy),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .field_index_o (field_index_o),
    .field_value_o (field_value_o),
    .last_field_o  (last_field_o)
  );

`ifndef NO_ASSERTIONS
  a_start_stalls_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_ok |=> !in_ready_o)
    else $error("Input was not stalled after a good frame.");

  a_first_field_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> field_index_o == FIELD_MSG_COUNT)
    else $error("A frame did not start with the message count field.");

  a_last_ends_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && last_field_o |=> !out_valid_o)
    else $error("A result followed the last field of a frame.");

  a_no_write_while_reading: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd.en |-> !wr.en)
    else $error("Frame store written while fields were being read.");
`endif

endmodule

FILE: rtl/imu_fsc_store.sv
// ----------------------------------------------------------------------------
// IMU frame store
// Word-wide frame memory with byte-lane writes and a registered read port.
// ----------------------------------------------------------------------------
module imu_fsc_store (
  input  logic              clk_i,
  input  imu_fsc_pkg::wr_t  wr_i,
  input  imu_fsc_pkg::rd_t  rd_i,
  output logic [31:0]       rd_data_o
);
  import imu_fsc_pkg::*;

  logic [3:0][7:0] mem_q [MEM_WORDS];
  logic [31:0]     rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr][2'd3 - wr_i.lane] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      rd_data_q <= mem_q[rd_i.addr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: rtl/imu_fsc_parser.sv
// ----------------------------------------------------------------------------
// IMU frame parser front end
// Sync hunt, byte collection into the frame store and checksum check.
// ----------------------------------------------------------------------------
module imu_fsc_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_index_i,
  input  logic [7:0]        cfg_data_i,
  input  logic              accept_i,
  input  logic [7:0]        rx_byte_i,
  output imu_fsc_pkg::wr_t  wr_o,
  output logic              frame_ok_o
);
  import imu_fsc_pkg::*;

  logic [7:0]       sync_first_q, sync_second_q;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [15:0]      sum_q, sum_d;
  logic [7:0]       check_hi_q;
  logic [15:0]      term;
  logic [15:0]      expect_sum;
  logic             frame_ok;

  assign term       = pos_q[0] ? {8'h00, rx_byte_i} : {rx_byte_i, 8'h00};
  assign expect_sum = (~sum_q) + 16'd1;

  always_comb begin
    pos_d    = pos_q;
    sum_d    = sum_q;
    frame_ok = 1'b0;
    wr_o     = '0;
    wr_o.addr = pos_q[POS_W-1:2];
    wr_o.lane = pos_q[1:0];
    wr_o.data = rx_byte_i;
    if (accept_i) begin
      if (pos_q == POS_HUNT) begin
        if (rx_byte_i == sync_first_q) begin
          wr_o.en = 1'b1;
          sum_d   = term;
          pos_d   = POS_SYNC;
        end
      end else if (pos_q == POS_SYNC) begin
        if (rx_byte_i == sync_second_q) begin
          wr_o.en = 1'b1;
          sum_d   = sum_q + term;
          pos_d   = pos_q + 7'd1;
        end else begin
          sum_d = '0;
          pos_d = POS_HUNT;
        end
      end else if (pos_q >= POS_FRAME_END) begin
        sum_d = '0;
        pos_d = POS_HUNT;
      end else begin
        wr_o.en = 1'b1;
        if (pos_q < POS_SUM_END) begin
          sum_d = sum_q + term;
        end
        if (pos_q == POS_CHECK_LO) begin
          frame_ok = (expect_sum == {check_hi_q, rx_byte_i});
          sum_d    = '0;
          pos_d    = POS_HUNT;
        end else begin
          pos_d = pos_q + 7'd1;
        end
      end
    end
  end

  assign frame_ok_o = frame_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_first_q  <= SYNC_FIRST_RST;
      sync_second_q <= SYNC_SECOND_RST;
      pos_q         <= POS_HUNT;
      sum_q         <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_SYNC_FIRST) begin
          sync_first_q <= cfg_data_i;
        end else begin
          sync_second_q <= cfg_data_i;
        end
      end
      pos_q <= pos_d;
      sum_q <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && pos_q == POS_CHECK_HI) begin
      check_hi_q <= rx_byte_i;
    end
  end

endmodule

FILE: rtl/imu_fsc_emit.sv
// ----------------------------------------------------------------------------
// IMU frame field emitter
// Reads the sixteen fields of a good frame from the store, one per request.
// ----------------------------------------------------------------------------
module imu_fsc_emit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [31:0]       rd_data_i,
  output imu_fsc_pkg::rd_t  rd_o,
  output logic              busy_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [3:0]        field_index_o,
  output logic [31:0]       field_value_o,
  output logic              last_field_o
);
  import imu_fsc_pkg::*;

  logic       busy_q;
  logic [3:0] cnt_q;
  logic       valid_q;
  logic [3:0] idx_q;
  logic       last_q;
  logic       advance;

  assign advance   = !valid_q || out_ready_i;
  assign rd_o.en   = busy_q && advance;
  assign rd_o.addr = field_word(cnt_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      cnt_q   <= '0;
      valid_q <= 1'b0;
      idx_q   <= '0;
      last_q  <= 1'b0;
    end else begin
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end
      if (advance) begin
        if (busy_q) begin
          valid_q <= 1'b1;
          idx_q   <= cnt_q;
          last_q  <= (cnt_q == FIELD_OP_FLAGS);
          cnt_q   <= cnt_q + 4'd1;
          if (cnt_q == FIELD_OP_FLAGS) begin
            busy_q <= 1'b0;
          end
        end else begin
          valid_q <= 1'b0;
        end
      end
    end
  end

  always_comb begin
    case (idx_q)
      FIELD_MSG_COUNT:   field_value_o = {16'h0000, rd_data_i[15:0]};
      FIELD_START_FLAGS: field_value_o = {16'h0000, rd_data_i[31:16]};
      FIELD_OP_FLAGS:    field_value_o = {16'h0000, rd_data_i[15:0]};
      default:           field_value_o = rd_data_i;
    endcase
  end

  assign busy_o        = busy_q;
  assign out_valid_o   = valid_q;
  assign field_index_o = idx_q;
  assign last_field_o  = last_q;

endmodule

FILE: tb/imu_frame_sync_checksum_parser_core_tb.sv
// ----------------------------------------------------------------------------
// IMU frame parser testbench
// Streams sync pairs, whole frames, broken frames and noise bytes into the
// parser. Each accepted byte updates a local model of the parser, and the
// model queues the sixteen fields that a good frame must produce. The output
// stream is compared with that queue. A directed table comes first, and then
// a random mix of frames under randomly chosen sync values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module imu_frame_sync_checksum_parser_core_tb;
  import imu_fsc_pkg::*;

  localparam int SETTLE      = 40;
  localparam int CYCLE_LIMIT = 300000;
  localparam int RANDOM_BYTES = 40;

  localparam int FIELD_OFS [16] = '{2, 4, 8, 12, 16, 20, 24, 32, 36, 40, 44, 48, 52, 56, 60, 62};
  localparam int FIELD_LEN [16] = '{2, 4, 4, 4, 4, 4, 4, 4, 4, 4, 4, 4, 4, 4, 2, 2};

  typedef struct packed {
    logic [3:0]  index;
    logic [31:0] value;
    logic        last;
  } field_result_t;

  typedef enum logic [2:0] {
    ROW_CFG, ROW_FILL, ROW_BADSUM, ROW_BADSYNC, ROW_NOISE, ROW_MIDCFG
  } row_kind_e;

  typedef struct packed {
    row_kind_e  kind;
    logic [7:0] a;
    logic [7:0] b;
  } stim_row_t;

  localparam logic [7:0] IDX_FIRST  = {7'd0, CFG_SYNC_FIRST};
  localparam logic [7:0] IDX_SECOND = {7'd0, CFG_SYNC_SECOND};

  localparam int ROWS = 9;
  localparam stim_row_t DIRECTED [ROWS] = '{
    '{ROW_FILL,    8'h00,      8'h00},
    '{ROW_BADSUM,  8'hA5,      8'h00},
    '{ROW_NOISE,   8'hAA,      8'h00},
    '{ROW_BADSYNC, 8'h11,      8'h00},
    '{ROW_FILL,    8'hFF,      8'h00},
    '{ROW_CFG,     IDX_FIRST,  8'h00},
    '{ROW_CFG,     IDX_SECOND, 8'hFF},
    '{ROW_BADSYNC, 8'h00,      8'h00},
    '{ROW_MIDCFG,  8'h3C,      8'h12}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_index_i = 1'b0;
  logic [7:0]  cfg_data_i = 8'h00;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  rx_byte_i = 8'h00;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [3:0]  field_index_o;
  logic [31:0] field_value_o;
  logic        last_field_o;

  // Sideband that travels with each byte: a typed expectation for the frame.
  logic        tag_typed = 1'b0;
  logic        tag_good = 1'b0;
  logic [7:0]  tag_fill = 8'h00;

  imu_frame_sync_checksum_parser_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .rx_byte_i     (rx_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .field_index_o (field_index_o),
    .field_value_o (field_value_o),
    .last_field_o  (last_field_o)
  );

  always #4 clk_i = ~clk_i;

  // Parser model state.
  logic [7:0]  mdl_first = SYNC_FIRST_RST;
  logic [7:0]  mdl_second = SYNC_SECOND_RST;
  int          mdl_pos = 0;
  logic [15:0] mdl_sum = '0;
  logic [7:0]  mdl_store [FRAME_BYTES];

  field_result_t pending_fields [$];
  int            errors = 0;
  int            cycle_count = 0;

  // Generator side copy of the sync values and the frame being sent.
  logic [7:0] cur_first = SYNC_FIRST_RST;
  logic [7:0] cur_second = SYNC_SECOND_RST;
  logic [7:0] frame_buf [FRAME_BYTES];
  int         burst_left = 0;

  function automatic logic [31:0] fill_field(input logic [3:0] idx, input logic [7:0] f);
    if (idx == FIELD_MSG_COUNT || idx >= FIELD_START_FLAGS) begin
      return {16'h0000, f, f};
    end
    return {f, f, f, f};
  endfunction

  task automatic parse_rx_byte(input logic [7:0] b);
    logic [15:0]   want;
    logic [15:0]   given;
    logic [31:0]   v;
    field_result_t r;
    if (mdl_pos == int'(POS_HUNT)) begin
      if (b == mdl_first) begin
        mdl_store[0] = b;
        mdl_sum = {b, 8'h00};
        mdl_pos = 1;
      end
    end else if (mdl_pos == int'(POS_SYNC)) begin
      if (b == mdl_second) begin
        mdl_store[1] = b;
        mdl_sum = mdl_sum + {8'h00, b};
        mdl_pos = 2;
      end else begin
        mdl_pos = 0;
        mdl_sum = '0;
      end
    end else begin
      mdl_store[mdl_pos] = b;
      if (mdl_pos < int'(POS_SUM_END)) begin
        mdl_sum = mdl_sum + ((mdl_pos % 2) ? {8'h00, b} : {b, 8'h00});
      end
      mdl_pos++;
      if (mdl_pos == int'(POS_FRAME_END)) begin
        mdl_pos = 0;
        want = ~mdl_sum + 16'd1;
        given = {mdl_store[POS_CHECK_HI], mdl_store[POS_CHECK_LO]};
        mdl_sum = '0;
        if (want == given) begin
          for (int k = 0; k < 16; k++) begin
            v = '0;
            for (int j = 0; j < FIELD_LEN[k]; j++) begin
              v = {v[23:0], mdl_store[FIELD_OFS[k] + j]};
            end
            r.index = 4'(k);
            r.value = v;
            r.last = (4'(k) == FIELD_OP_FLAGS);
            pending_fields.push_back(r);
          end
        end
      end
    end
  endtask

  task automatic take_byte(input logic [7:0] b, input logic typed, input logic good,
                           input logic [7:0] f);
    int            n;
    field_result_t r;
    n = pending_fields.size();
    parse_rx_byte(b);
    if (typed) begin
      while (pending_fields.size() > n) begin
        void'(pending_fields.pop_back());
      end
      if (good) begin
        for (int k = 0; k < 16; k++) begin
          r.index = 4'(k);
          r.value = fill_field(4'(k), f);
          r.last = (4'(k) == FIELD_OP_FLAGS);
          pending_fields.push_back(r);
        end
      end
    end
  endtask

  always @(posedge clk_i) begin
    field_result_t got;
    field_result_t want;
    if (rst_ni) begin
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_SYNC_FIRST) begin
          mdl_first = cfg_data_i;
        end else begin
          mdl_second = cfg_data_i;
        end
      end
      if (in_valid_i && in_ready_o) begin
        take_byte(rx_byte_i, tag_typed, tag_good, tag_fill);
      end
      if (out_valid_o && out_ready_i) begin
        got = '{field_index_o, field_value_o, last_field_o};
        if (pending_fields.size() == 0) begin
          $display("%0t: unexpected result, actual index %0d value %h last %b",
                   $time, got.index, got.value, got.last);
          errors++;
        end else begin
          want = pending_fields.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch, expected %0d %h %b, actual %0d %h %b",
                     $time, want.index, want.value, want.last,
                     got.index, got.value, got.last);
            errors++;
          end
        end
      end
    end
  end

  // Receiver: back-pressure in randomly chosen modes that change after a random span.
  int rdy_mode = 0;
  int rdy_phase = 0;
  int rdy_span = 100;

  always @(posedge clk_i) begin
    if (rdy_phase >= rdy_span) begin
      rdy_phase <= 0;
      rdy_span <= $urandom_range(64, 256);
      rdy_mode <= $urandom_range(0, 3);
    end else begin
      rdy_phase <= rdy_phase + 1;
    end
    case (rdy_mode)
      0: begin
        out_ready_i <= 1'b1;
      end
      1: begin
        out_ready_i <= ($urandom_range(0, 3) != 0);
      end
      2: begin
        out_ready_i <= ((rdy_phase % 5) == 0);
      end
      default: begin
        out_ready_i <= ((rdy_phase % 24) >= 20);
      end
    endcase
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic typed, input logic good,
                           input logic [7:0] f);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 10);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 250)
                                                : $urandom_range(1, 30);
    end
    in_valid_i <= 1'b1;
    rx_byte_i <= b;
    tag_typed <= typed;
    tag_good <= good;
    tag_fill <= f;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    burst_left--;
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] val);
    in_valid_i <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending_fields.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_SYNC_FIRST) begin
      cur_first = val;
    end else begin
      cur_second = val;
    end
  endtask

  // Fills frame_buf with the current sync pair, a body and a checksum that
  // is off by ck_delta.
  task automatic build_frame(input logic rand_body, input logic [7:0] f,
                             input logic [15:0] ck_delta);
    logic [15:0] s;
    int          r;
    frame_buf[0] = cur_first;
    frame_buf[1] = cur_second;
    for (int i = 2; i < int'(POS_CHECK_HI); i++) begin
      r = $urandom_range(0, 15);
      if (!rand_body) begin
        frame_buf[i] = f;
      end else if (r == 0) begin
        frame_buf[i] = cur_first;
      end else if (r == 1) begin
        frame_buf[i] = cur_second;
      end else begin
        frame_buf[i] = 8'($urandom);
      end
    end
    s = '0;
    for (int w = 0; w < WORD_COUNT; w++) begin
      s = s + {frame_buf[2 * w], frame_buf[2 * w + 1]};
    end
    s = ~s + 16'd1 + ck_delta;
    frame_buf[POS_CHECK_HI] = s[15:8];
    frame_buf[POS_CHECK_LO] = s[7:0];
  endtask

  task automatic send_frame(input int first_byte, input int nbytes, input int split_at,
                            input logic [7:0] split_val, input logic typed,
                            input logic good, input logic [7:0] f);
    for (int i = first_byte; i < nbytes; i++) begin
      if (i == split_at) begin
        write_reg(CFG_SYNC_FIRST, split_val);
      end
      send_byte(frame_buf[i], typed && (i == FRAME_BYTES - 1), good, f);
    end
  endtask

  initial begin
    stim_row_t  row;
    logic [7:0] wrong;
    int         counted;
    int         pick;
    int         n;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < ROWS; i++) begin
      row = DIRECTED[i];
      case (row.kind)
        ROW_CFG: begin
          write_reg(row.a[0], row.b);
        end
        ROW_FILL: begin
          build_frame(1'b0, row.a, 16'd0);
          send_frame(0, FRAME_BYTES, -1, 8'h00, 1'b1, 1'b1, row.a);
        end
        ROW_BADSUM: begin
          build_frame(1'b0, row.a, 16'd1);
          send_frame(0, FRAME_BYTES, -1, 8'h00, 1'b1, 1'b0, row.a);
        end
        ROW_BADSYNC: begin
          wrong = (cur_first != cur_second) ? cur_first : ~cur_second;
          send_byte(cur_first, 1'b0, 1'b0, 8'h00);
          send_byte(wrong, 1'b0, 1'b0, 8'h00);
        end
        ROW_NOISE: begin
          send_byte(row.a, 1'b0, 1'b0, 8'h00);
        end
        default: begin
          build_frame(1'b0, row.a, 16'd0);
          send_frame(0, FRAME_BYTES, 34, row.b, 1'b1, 1'b1, row.a);
        end
      endcase
    end

    counted = 0;
    while (counted < RANDOM_BYTES) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        build_frame(1'b1, 8'h00, 16'd0);
        send_frame(0, FRAME_BYTES, -1, 8'h00, 1'b0, 1'b0, 8'h00);
        counted += FRAME_BYTES;
      end else if (pick < 70) begin
        build_frame(1'b1, 8'h00, 16'($urandom_range(1, 65535)));
        send_frame(0, FRAME_BYTES, -1, 8'h00, 1'b0, 1'b0, 8'h00);
        counted += FRAME_BYTES;
      end else if (pick < 80) begin
        send_byte(cur_first, 1'b0, 1'b0, 8'h00);
        send_byte(8'($urandom), 1'b0, 1'b0, 8'h00);
        counted += 2;
      end else if (pick < 88) begin
        n = $urandom_range(1, 5);
        repeat (n) send_byte(8'($urandom), 1'b0, 1'b0, 8'h00);
        counted += n;
      end else if (pick < 94) begin
        n = $urandom_range(3, FRAME_BYTES - 1);
        build_frame(1'b1, 8'h00, 16'd0);
        send_frame(0, n, -1, 8'h00, 1'b0, 1'b0, 8'h00);
        counted += n;
      end else begin
        pick = $urandom_range(0, 3);
        if (pick == 0) begin
          write_reg(CFG_SYNC_FIRST, SYNC_FIRST_RST);
          write_reg(CFG_SYNC_SECOND, SYNC_SECOND_RST);
        end else begin
          write_reg(1'($urandom), 8'($urandom));
        end
      end
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_fields.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/imu_fsc_pkg.sv
rtl/imu_fsc_store.sv
rtl/imu_fsc_parser.sv
rtl/imu_fsc_emit.sv
rtl/imu_frame_sync_checksum_parser_core.sv
tb/imu_frame_sync_checksum_parser_core_tb.sv
